[rtl/risc_instruction_executor_macros.svh]
// ----------------------------------------------------------------------------
// risc_instruction_executor_macros
// Assertion macros for the top-level file that checks this block.
// ----------------------------------------------------------------------------
`ifndef RISC_INSTRUCTION_EXECUTOR_MACROS_SVH
`define RISC_INSTRUCTION_EXECUTOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RIE_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RIE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/rie_pkg.sv]
// ----------------------------------------------------------------------------
// rie_pkg
// Constants, codes and types shared by the instruction executor.
// ----------------------------------------------------------------------------
package rie_pkg;

	localparam int DATA_DEPTH  = 4096;
	localparam int STACK_DEPTH = 8;
	localparam int PC_WIDTH    = 16;
	localparam int REG_COUNT   = 32;
	localparam int QUEUE_DEPTH = 2;

	localparam int DADDR_W = $clog2(DATA_DEPTH);
	localparam int SIDX_W  = $clog2(STACK_DEPTH);
	localparam int SCNT_W  = $clog2(STACK_DEPTH + 1);
	localparam int RIDX_W  = $clog2(REG_COUNT);
	localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int NPC_W   = 16;

	localparam logic [5:0] OP_ADDI = 6'h08;
	localparam logic [5:0] OP_SUBI = 6'h09;
	localparam logic [5:0] OP_ANDI = 6'h0C;
	localparam logic [5:0] OP_ORI  = 6'h0D;
	localparam logic [5:0] OP_LW   = 6'h23;
	localparam logic [5:0] OP_SW   = 6'h2B;
	localparam logic [5:0] OP_CMP  = 6'h1D;
	localparam logic [5:0] OP_RA   = 6'h00;
	localparam logic [5:0] OP_RB   = 6'h1C;
	localparam logic [5:0] OP_RC   = 6'h05;
	localparam logic [5:0] OP_JMP  = 6'h11;
	localparam logic [5:0] OP_JREL = 6'h02;
	localparam logic [5:0] OP_BR   = 6'h04;
	localparam logic [5:0] OP_CALL = 6'h03;
	localparam logic [5:0] OP_RET  = 6'h01;
	localparam logic [5:0] OP_HALT = 6'h3F;

	localparam logic [5:0] FN_ADD = 6'h20;
	localparam logic [5:0] FN_SUB = 6'h22;
	localparam logic [5:0] FN_AND = 6'h24;
	localparam logic [5:0] FN_OR  = 6'h25;
	localparam logic [5:0] FN_MUL = 6'h02;
	localparam logic [5:0] FN_DIV = 6'h01;
	localparam logic [5:0] FN_NOT = 6'h27;

	localparam logic [2:0] FLAG_LESS    = 3'd0;
	localparam logic [2:0] FLAG_EQUAL   = 3'd1;
	localparam logic [2:0] FLAG_GREATER = 3'd4;

	localparam logic [2:0] FAULT_NONE   = 3'd0;
	localparam logic [2:0] FAULT_OPCODE = 3'd1;
	localparam logic [2:0] FAULT_FULL   = 3'd2;
	localparam logic [2:0] FAULT_EMPTY  = 3'd3;
	localparam logic [2:0] FAULT_DIV    = 3'd4;

	typedef enum logic [4:0] {
		CLS_ADDI, CLS_SUBI, CLS_ANDI, CLS_ORI, CLS_LW, CLS_SW, CLS_CMP,
		CLS_ADD, CLS_SUB, CLS_AND, CLS_OR, CLS_MUL, CLS_DIV, CLS_NOT, CLS_RNOP,
		CLS_JMP, CLS_JREL, CLS_BR, CLS_CALL, CLS_RET, CLS_HALT, CLS_BAD
	} cls_t;

	typedef struct packed {
		cls_t              cls;
		logic [RIDX_W-1:0] ra;
		logic [RIDX_W-1:0] rb;
		logic [RIDX_W-1:0] wi;
		logic [15:0]       imm;
		logic [25:0]       target;
	} decoded_t;

	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_EXEC, ST_LOAD, ST_DIV, ST_DIVSGN, ST_DONE
	} back_state_t;

	typedef struct packed {
		logic clearing;
		logic halted;
	} status_t;

endpackage

[rtl/rie_instr_if.sv]
// ----------------------------------------------------------------------------
// rie_instr_if
// Instruction channel: one instruction word per handshake.
// ----------------------------------------------------------------------------
interface rie_instr_if;
	logic        valid;
	logic        ready;
	logic [31:0] instruction_word;

	modport source (output valid, output instruction_word, input ready);
	modport sink (input valid, input instruction_word, output ready);
endinterface

[rtl/rie_result_if.sv]
// ----------------------------------------------------------------------------
// rie_result_if
// Result channel: the outcome of one instruction per handshake.
// ----------------------------------------------------------------------------
interface rie_result_if;
	import rie_pkg::*;

	logic             valid;
	logic             ready;
	logic [NPC_W-1:0] next_pc;
	logic             write_enable;
	logic [4:0]       write_index;
	logic [31:0]      write_value;
	logic [2:0]       compare_flag;
	logic             halted;
	logic [2:0]       fault_code;

	modport source (output valid, output next_pc, output write_enable, output write_index,
		output write_value, output compare_flag, output halted, output fault_code,
		input ready);
	modport sink (input valid, input next_pc, input write_enable, input write_index,
		input write_value, input compare_flag, input halted, input fault_code,
		output ready);
endinterface

[rtl/rie_front.sv]
// ----------------------------------------------------------------------------
// rie_front
// Accepts instruction words and classifies them for the back end.
// ----------------------------------------------------------------------------
module rie_front (
	rie_instr_if.sink          instr,
	input  rie_pkg::status_t   status,
	input  logic               q_full,
	output logic               push,
	output rie_pkg::decoded_t  push_item
);
	import rie_pkg::*;

	logic [5:0]  op;
	logic [5:0]  fn;
	logic [31:0] w;

	assign w  = instr.instruction_word;
	assign op = w[31:26];
	assign fn = w[5:0];

	assign instr.ready = !q_full && !status.clearing;
	assign push        = instr.valid && instr.ready;

	always_comb begin
		push_item.ra     = w[25:21];
		push_item.rb     = w[20:16];
		push_item.wi     = w[20:16];
		push_item.imm    = w[15:0];
		push_item.target = w[25:0];
		push_item.cls    = CLS_BAD;
		unique case (op)
			OP_ADDI: push_item.cls = CLS_ADDI;
			OP_SUBI: push_item.cls = CLS_SUBI;
			OP_ANDI: push_item.cls = CLS_ANDI;
			OP_ORI:  push_item.cls = CLS_ORI;
			OP_LW:   push_item.cls = CLS_LW;
			OP_SW:   push_item.cls = CLS_SW;
			OP_CMP:  push_item.cls = CLS_CMP;
			OP_RA, OP_RB, OP_RC: begin
				push_item.wi = w[15:11];
				unique case (fn)
					FN_ADD:  push_item.cls = CLS_ADD;
					FN_SUB:  push_item.cls = CLS_SUB;
					FN_AND:  push_item.cls = CLS_AND;
					FN_OR:   push_item.cls = CLS_OR;
					FN_MUL:  push_item.cls = CLS_MUL;
					FN_DIV:  push_item.cls = CLS_DIV;
					FN_NOT:  push_item.cls = CLS_NOT;
					default: push_item.cls = CLS_RNOP;
				endcase
			end
			OP_JMP:  push_item.cls = CLS_JMP;
			OP_JREL: push_item.cls = CLS_JREL;
			OP_BR: begin
				push_item.cls = CLS_BR;
				push_item.ra  = w[15:11];
			end
			OP_CALL: push_item.cls = CLS_CALL;
			OP_RET:  push_item.cls = CLS_RET;
			OP_HALT: push_item.cls = CLS_HALT;
			default: push_item.cls = CLS_BAD;
		endcase
	end

endmodule

[rtl/rie_queue.sv]
// ----------------------------------------------------------------------------
// rie_queue
// Short queue of classified instructions between the front and back ends.
// ----------------------------------------------------------------------------
module rie_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  rie_pkg::decoded_t push_item,
	input  logic              pop,
	output logic              full,
	output logic              not_empty,
	output rie_pkg::decoded_t head
);
	import rie_pkg::*;

	decoded_t          slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full      = count_q == QCNT_W'(QUEUE_DEPTH);
	assign not_empty = count_q != '0;
	assign head      = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

[rtl/rie_back.sv]
// ----------------------------------------------------------------------------
// rie_back
// Executes classified instructions against the register file, data memory,
// flag and call stack, and holds the result word until it is taken.
// ----------------------------------------------------------------------------
module rie_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_not_empty,
	input  rie_pkg::decoded_t q_head,
	output logic              pop,
	output rie_pkg::status_t  status,
	rie_result_if.source      result
);
	import rie_pkg::*;

	back_state_t state_q, state_d;

	logic [31:0]         rf [REG_COUNT];
	logic [REG_COUNT-1:0] rf_valid_q;
	logic [31:0]         ra_raw_q, rb_raw_q;
	logic                ra_vld_q, rb_vld_q;
	logic [31:0]         a_val, b_val;

	logic [31:0]         dmem [DATA_DEPTH];
	logic [DADDR_W-1:0]  clr_idx_q;
	logic [31:0]         mem_rd_q;
	logic [DADDR_W-1:0]  mem_addr;
	logic                mem_we;
	logic [31:0]         mem_wdata;

	logic [PC_WIDTH-1:0] stack [STACK_DEPTH];
	logic [SCNT_W-1:0]   scnt_q;

	logic [PC_WIDTH-1:0] pc_q, pc_inc, exec_pc;
	logic [2:0]          flag_q, exec_flag;
	logic                halt_q;

	decoded_t            item_q;
	logic                res_we_q;
	logic [31:0]         res_wv_q;
	logic [2:0]          res_fault_q;
	logic                exec_we;
	logic [31:0]         exec_wv;
	logic [2:0]          exec_fault;
	logic                exec_push, exec_popstk;

	logic [31:0]         div_rem_q, div_quo_q, div_den_q;
	logic                div_neg_q;
	logic [4:0]          div_cnt_q;
	logic [32:0]         div_trial;

	logic                out_free, load_out, clr_last;
	logic [63:0]         product;

	assign a_val     = ra_vld_q ? ra_raw_q : '0;
	assign b_val     = rb_vld_q ? rb_raw_q : '0;
	assign pc_inc    = pc_q + 1'b1;
	assign out_free  = !result.valid || result.ready;
	assign clr_last  = clr_idx_q == DADDR_W'(DATA_DEPTH - 1);
	assign product   = a_val * b_val;
	assign div_trial = {div_rem_q, div_quo_q[31]} - {1'b0, div_den_q};

	assign status.clearing = state_q == ST_CLEAR;
	assign status.halted   = halt_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (clr_last) state_d = ST_IDLE;
			ST_IDLE:  if (q_not_empty) state_d = ST_EXEC;
			ST_EXEC: begin
				if (halt_q) begin
					state_d = ST_DONE;
				end else if (item_q.cls == CLS_LW) begin
					state_d = ST_LOAD;
				end else if (item_q.cls == CLS_DIV && b_val != '0) begin
					state_d = ST_DIV;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_LOAD:   state_d = ST_DONE;
			ST_DIV:    if (div_cnt_q == 5'd31) state_d = ST_DIVSGN;
			ST_DIVSGN: state_d = ST_DONE;
			ST_DONE:   if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		pop       = state_q == ST_IDLE && q_not_empty;
		load_out  = state_q == ST_DONE && out_free;
		mem_we    = 1'b0;
		mem_wdata = b_val;
		mem_addr  = a_val[DADDR_W-1:0];
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_wdata = '0;
			mem_addr  = clr_idx_q;
		end else if (state_q == ST_EXEC && !halt_q && item_q.cls == CLS_SW) begin
			mem_we = 1'b1;
		end
	end

	always_comb begin
		exec_pc     = pc_inc;
		exec_flag   = flag_q;
		exec_we     = 1'b0;
		exec_wv     = '0;
		exec_fault  = FAULT_NONE;
		exec_push   = 1'b0;
		exec_popstk = 1'b0;
		if (halt_q) begin
			exec_pc = pc_q;
		end else begin
			unique case (item_q.cls)
				CLS_ADDI: begin exec_we = 1'b1; exec_wv = a_val + {16'd0, item_q.imm}; end
				CLS_SUBI: begin exec_we = 1'b1; exec_wv = a_val - {16'd0, item_q.imm}; end
				CLS_ANDI: begin exec_we = 1'b1; exec_wv = a_val & {16'd0, item_q.imm}; end
				CLS_ORI:  begin exec_we = 1'b1; exec_wv = a_val | {16'd0, item_q.imm}; end
				CLS_LW:   exec_we = 1'b1;
				CLS_SW:   exec_we = 1'b0;
				CLS_CMP: begin
					if (a_val == {16'd0, item_q.imm}) begin
						exec_flag = FLAG_EQUAL;
					end else if (!a_val[31] && a_val > {16'd0, item_q.imm}) begin
						exec_flag = FLAG_GREATER;
					end else begin
						exec_flag = FLAG_LESS;
					end
				end
				CLS_ADD:  begin exec_we = 1'b1; exec_wv = a_val + b_val; end
				CLS_SUB:  begin exec_we = 1'b1; exec_wv = a_val - b_val; end
				CLS_AND:  begin exec_we = 1'b1; exec_wv = a_val & b_val; end
				CLS_OR:   begin exec_we = 1'b1; exec_wv = a_val | b_val; end
				CLS_MUL:  begin exec_we = 1'b1; exec_wv = product[31:0]; end
				CLS_DIV: begin
					exec_we = 1'b1;
					if (b_val == '0) begin
						exec_wv    = '1;
						exec_fault = FAULT_DIV;
					end
				end
				CLS_NOT:  begin exec_we = 1'b1; exec_wv = ~b_val; end
				CLS_RNOP: exec_we = 1'b0;
				CLS_JMP:  exec_pc = item_q.target[PC_WIDTH-1:0];
				CLS_JREL: exec_pc = pc_inc + item_q.target[PC_WIDTH-1:0];
				CLS_BR: begin
					if (flag_q == FLAG_EQUAL || flag_q == FLAG_GREATER) begin
						exec_pc = a_val[PC_WIDTH-1:0];
					end
				end
				CLS_CALL: begin
					if (scnt_q >= SCNT_W'(STACK_DEPTH)) begin
						exec_fault = FAULT_FULL;
					end else begin
						exec_push = 1'b1;
						exec_pc   = item_q.target[PC_WIDTH-1:0];
					end
				end
				CLS_RET: begin
					if (scnt_q == '0) begin
						exec_fault = FAULT_EMPTY;
					end else begin
						exec_popstk = 1'b1;
						exec_pc     = stack[SIDX_W'(scnt_q - 1'b1)];
					end
				end
				CLS_HALT: exec_pc = pc_q;
				CLS_BAD:  exec_fault = FAULT_OPCODE;
				default:  exec_fault = FAULT_OPCODE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_idx_q    <= '0;
			rf_valid_q   <= '0;
			pc_q         <= '0;
			flag_q       <= FLAG_LESS;
			halt_q       <= 1'b0;
			scnt_q       <= '0;
			result.valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
			if (state_q == ST_EXEC) begin
				pc_q   <= exec_pc;
				flag_q <= exec_flag;
				if (!halt_q && item_q.cls == CLS_HALT) begin
					halt_q <= 1'b1;
				end
				if (exec_push) begin
					scnt_q <= scnt_q + 1'b1;
				end else if (exec_popstk) begin
					scnt_q <= scnt_q - 1'b1;
				end
			end
			if (load_out && res_we_q) begin
				rf_valid_q[item_q.wi] <= 1'b1;
			end
			if (load_out) begin
				result.valid <= 1'b1;
			end else if (result.ready) begin
				result.valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_q   <= q_head;
			ra_raw_q <= rf[q_head.ra];
			rb_raw_q <= rf[q_head.rb];
			ra_vld_q <= rf_valid_q[q_head.ra];
			rb_vld_q <= rf_valid_q[q_head.rb];
		end
		if (load_out && res_we_q) begin
			rf[item_q.wi] <= res_wv_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			dmem[mem_addr] <= mem_wdata;
		end
		mem_rd_q <= dmem[mem_addr];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EXEC && exec_push) begin
			stack[scnt_q[SIDX_W-1:0]] <= pc_inc;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_EXEC: begin
				res_we_q    <= exec_we;
				res_wv_q    <= exec_wv;
				res_fault_q <= exec_fault;
				div_rem_q   <= '0;
				div_quo_q   <= a_val[31] ? (32'd0 - a_val) : a_val;
				div_den_q   <= b_val[31] ? (32'd0 - b_val) : b_val;
				div_neg_q   <= a_val[31] != b_val[31];
				div_cnt_q   <= '0;
			end
			ST_LOAD: res_wv_q <= mem_rd_q;
			ST_DIV: begin
				div_cnt_q <= div_cnt_q + 1'b1;
				div_quo_q <= {div_quo_q[30:0], ~div_trial[32]};
				div_rem_q <= div_trial[32] ? {div_rem_q[30:0], div_quo_q[31]} : div_trial[31:0];
			end
			ST_DIVSGN: res_wv_q <= div_neg_q ? (32'd0 - div_quo_q) : div_quo_q;
			default: begin
			end
		endcase
		if (load_out) begin
			result.next_pc      <= NPC_W'(pc_q);
			result.write_enable <= res_we_q;
			result.write_index  <= res_we_q ? item_q.wi : '0;
			result.write_value  <= res_we_q ? res_wv_q : '0;
			result.compare_flag <= flag_q;
			result.halted       <= halt_q;
			result.fault_code   <= res_fault_q;
		end
	end

endmodule

[rtl/risc_instruction_executor.sv]
// ----------------------------------------------------------------------------
// risc_instruction_executor
// Executes one 32-bit instruction per word and reports its effect.
// ----------------------------------------------------------------------------
// After reset the block clears all 4096 words of its data memory, one word a
// cycle, and accepts no word until that is done. Each instruction then passes
// through the back end's sequencer states for register read, execute and
// result, a load through an extra state for the registered memory read, and a
// divide by a non-zero divisor through divide and sign states, its quotient
// formed one bit a cycle. A two-word queue lets the front end accept further
// words while the back end is busy, and the result register lets the next
// instruction start while a result waits.
module risc_instruction_executor (
	input  logic          clk,
	input  logic          arst_n,
	rie_instr_if.sink     instr,
	rie_result_if.source  result
);
	import rie_pkg::*;
	`include "risc_instruction_executor_macros.svh"

	status_t  status;
	decoded_t push_item, q_head;
	logic     push, pop, q_full, q_not_empty;

	rie_front u_front (
		.instr     (instr),
		.status    (status),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	rie_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	rie_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.pop         (pop),
		.status      (status),
		.result      (result)
	);

	`RIE_ASSERT_IMPL(a_no_accept_clearing, status.clearing, !instr.ready, "word accepted while memory clears")
	`RIE_ASSERT_NEXT(a_halt_sticky, status.halted, status.halted, "halt mark cleared")
	`RIE_ASSERT_IMPL(a_div_zero_ones, result.valid && result.fault_code == FAULT_DIV, result.write_enable && result.write_value == '1, "divide by zero result wrong")
	`RIE_ASSERT_IMPL(a_no_write_zero, result.valid && !result.write_enable, result.write_index == '0 && result.write_value == '0, "idle write fields not zero")

endmodule
